/* hdl/vkts_pkg.sv */
// ----------------------------------------------------------------------------
// vkts_pkg
// shared types and constants of the keyframe track sampler
// ----------------------------------------------------------------------------
package vkts_pkg;

   localparam int MaxKeysDefault      = 64;
   localparam int FractionBitsDefault = 16;
   localparam int KeyIndexWidth       = 6;
   localparam int CountWidth          = 7;
   localparam int DataWidth           = 32;

   localparam logic KindLoad  = 1'b0;
   localparam logic KindQuery = 1'b1;

   localparam logic [0:0] RegKeyCount = 1'b0;

   typedef struct packed {
      logic                      kind;
      logic [KeyIndexWidth-1:0]  key_index;
      logic [DataWidth-1:0]      key_time;
      logic signed [DataWidth-1:0] value_x;
      logic signed [DataWidth-1:0] value_y;
      logic signed [DataWidth-1:0] value_z;
      logic [DataWidth-1:0]      query_time;
   } req_type;

   typedef struct packed {
      logic                        found;
      logic [CountWidth-1:0]       upper_key;
      logic signed [DataWidth-1:0] out_x;
      logic signed [DataWidth-1:0] out_y;
      logic signed [DataWidth-1:0] out_z;
   } rsp_type;

endpackage

/* hdl/vkts_front.sv */
// ----------------------------------------------------------------------------
// vkts_front
// takes requests, buffers them in a two-entry queue for the back end
// ----------------------------------------------------------------------------
module vkts_front
   import vkts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type push_data,
   output logic    full,
   output logic    q_valid,
   output req_type q_data,
   input  logic    q_take
);

   req_type   slot_ff [2];
   req_type   slot_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push;

   assign full     = (cnt_ff == 2'd2);
   assign do_push  = push && !full;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_data   = slot_ff[0];

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      cnt_in     = cnt_ff;
      if (q_take && q_valid) begin
         slot_in[0] = slot_ff[1];
         cnt_in     = cnt_in - 2'd1;
      end
      if (do_push) begin
         slot_in[cnt_in[0]] = push_data;
         cnt_in             = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* hdl/vkts_back.sv */
// ----------------------------------------------------------------------------
// vkts_back
// key memory, binary search, fraction divider and blend sequencer
// ----------------------------------------------------------------------------
module vkts_back
   import vkts_pkg::*;
#(
   parameter int MAX_KEYS      = MaxKeysDefault,
   parameter int FRACTION_BITS = FractionBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  req_type               q_data,
   output logic                  q_take,
   input  logic [CountWidth-1:0] key_count,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  rsp_take
);

   localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int NW = AW + 1;
   localparam int DW = DataWidth;
   localparam int FW = FRACTION_BITS;
   localparam int PW = DW + 1 + FW + 1;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SRCH   = 9'b000000010,
      ST_SWAIT  = 9'b000000100,
      ST_RD0    = 9'b000001000,
      ST_RD1    = 9'b000010000,
      ST_DIV    = 9'b000100000,
      ST_MUL    = 9'b001000000,
      ST_SUM    = 9'b010000000,
      ST_OUT    = 9'b100000000
   } state_type;

   logic [DW-1:0] mem_t [MAX_KEYS];
   logic [DW-1:0] mem_x [MAX_KEYS];
   logic [DW-1:0] mem_y [MAX_KEYS];
   logic [DW-1:0] mem_z [MAX_KEYS];
   logic [DW-1:0] rd_t, rd_x, rd_y, rd_z;
   logic [AW-1:0] rd_addr;

   state_type     st_ff, st_in;
   logic [NW-1:0] lo_ff, lo_in, hi_ff, hi_in, n_ff, n_in;
   logic [DW-1:0] q_ff, q_in, t0_ff, t0_in;
   logic [DW-1:0] a_x_ff, a_x_in, a_y_ff, a_y_in, a_z_ff, a_z_in;
   logic [DW-1:0] b_x_ff, b_x_in, b_y_ff, b_y_in, b_z_ff, b_z_in;
   logic [DW-1:0]    den_ff, den_in;
   logic [FW:0]      frac_ff, frac_in;
   logic [5:0]       it_ff, it_in;
   logic signed [PW-1:0] p_x_ff, p_x_in, p_y_ff, p_y_in, p_z_ff, p_z_in;
   rsp_type       wk_ff, wk_in;
   rsp_type       res_ff, res_in;
   logic          rv_ff, rv_in;
   logic          do_load;
   logic [NW-1:0] mid;

   // divider datapath: partial remainder, dividend shift and quotient
   logic [DW:0]      div_r_ff, div_r_in;
   logic [DW+FW-1:0] div_n_ff, div_n_in;
   logic [FW:0]      div_f_ff, div_f_in;

   assign do_load = (st_ff == ST_IDLE) && q_valid && (q_data.kind == KindLoad);
   assign mid     = NW'((lo_ff + hi_ff) >> 1);

   always_comb begin
      rd_addr = mid[AW-1:0];
      if (st_ff == ST_IDLE || st_ff == ST_RD0) begin
         rd_addr = AW'(lo_ff - NW'(1));
      end else if (st_ff == ST_RD1 || st_ff == ST_SWAIT) begin
         rd_addr = lo_ff[AW-1:0];
      end
   end

   // key memories, registered reads
   always_ff @(posedge clock) begin
      if (do_load && (32'(q_data.key_index) < MAX_KEYS)) begin
         mem_t[AW'(q_data.key_index)] <= q_data.key_time;
         mem_x[AW'(q_data.key_index)] <= q_data.value_x;
         mem_y[AW'(q_data.key_index)] <= q_data.value_y;
         mem_z[AW'(q_data.key_index)] <= q_data.value_z;
      end
      rd_t <= mem_t[rd_addr];
      rd_x <= mem_x[rd_addr];
      rd_y <= mem_y[rd_addr];
      rd_z <= mem_z[rd_addr];
   end

   function automatic logic signed [PW-1:0] diff_mul(logic [DW-1:0] a, logic [DW-1:0] b,
                                                     logic [FW:0] f);
      logic signed [DW:0] d;
      d = $signed({b[DW-1], b}) - $signed({a[DW-1], a});
      return PW'(d * $signed({1'b0, f}));
   endfunction

   function automatic logic [DW-1:0] add_q(logic [DW-1:0] a, logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      s = p >>> FW;
      return a + s[DW-1:0];
   endfunction

   always_comb begin
      st_in = st_ff; lo_in = lo_ff; hi_in = hi_ff; n_in = n_ff; q_in = q_ff;
      t0_in = t0_ff; a_x_in = a_x_ff; a_y_in = a_y_ff; a_z_in = a_z_ff;
      b_x_in = b_x_ff; b_y_in = b_y_ff; b_z_in = b_z_ff;
      den_in = den_ff; frac_in = frac_ff; it_in = it_ff;
      p_x_in = p_x_ff; p_y_in = p_y_ff; p_z_in = p_z_ff;
      wk_in = wk_ff; res_in = res_ff; rv_in = rv_ff; q_take = 1'b0;
      if (rv_ff && rsp_take) rv_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_data.kind == KindLoad) begin
                  q_take = 1'b1;
               end else begin
                  q_take = 1'b1;
                  q_in   = q_data.query_time;
                  n_in   = (32'(key_count) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(key_count);
                  lo_in  = '0;
                  hi_in  = n_in;
                  if (n_in == '0) begin
                     wk_in = '0;
                     st_in = ST_OUT;
                  end else begin
                     st_in = ST_SRCH;
                  end
               end
            end
         end
         ST_SRCH: begin
            if (lo_ff < hi_ff) st_in = ST_SWAIT;
            else st_in = ST_RD0;
         end
         ST_SWAIT: begin
            // rd_t holds key at mid
            if (rd_t <= q_ff) lo_in = mid + NW'(1);
            else hi_in = mid;
            st_in = ST_SRCH;
         end
         ST_RD0: st_in = ST_RD1;
         ST_RD1: begin
            // key lo-1 data arrives
            t0_in = rd_t; a_x_in = rd_x; a_y_in = rd_y; a_z_in = rd_z;
            wk_in.found     = 1'b1;
            wk_in.upper_key = CountWidth'(lo_ff);
            if (lo_ff == '0) st_in = ST_DIV;
            else if (lo_ff == n_ff) begin
               wk_in.out_x = rd_x; wk_in.out_y = rd_y; wk_in.out_z = rd_z;
               st_in = ST_OUT;
            end else st_in = ST_DIV;
            it_in = '0;
         end
         ST_DIV: begin
            if (it_ff == '0) begin
               b_x_in = rd_x; b_y_in = rd_y; b_z_in = rd_z;
               if (lo_ff == '0) begin
                  wk_in.out_x = rd_x; wk_in.out_y = rd_y; wk_in.out_z = rd_z;
                  st_in = ST_OUT;
               end else begin
                  den_in  = rd_t - t0_ff;
                  frac_in = '0;
                  it_in   = 6'd1;
               end
            end else begin
               // restoring divide, one quotient bit a cycle
               it_in = it_ff + 6'd1;
               if (it_ff == 6'(DW + FW + 1)) begin
                  frac_in = div_f_ff;
                  st_in   = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            p_x_in = diff_mul(a_x_ff, b_x_ff, frac_ff);
            p_y_in = diff_mul(a_y_ff, b_y_ff, frac_ff);
            p_z_in = diff_mul(a_z_ff, b_z_ff, frac_ff);
            st_in  = ST_SUM;
         end
         ST_SUM: begin
            wk_in.out_x = add_q(a_x_ff, p_x_ff);
            wk_in.out_y = add_q(a_y_ff, p_y_ff);
            wk_in.out_z = add_q(a_z_ff, p_z_ff);
            st_in = ST_OUT;
         end
         ST_OUT: begin
            // finished result moves to the output register once it is free
            if (!rv_ff || rsp_take) begin
               res_in = wk_ff;
               rv_in  = 1'b1;
               st_in  = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      logic [DW:0] sh;
      div_r_in = div_r_ff; div_n_in = div_n_ff; div_f_in = div_f_ff;
      sh = '0;
      if (st_ff == ST_DIV && it_ff == '0) begin
         div_r_in = '0;
         div_n_in = {q_ff - t0_ff, FW'(0)};
         div_f_in = '0;
      end else if (st_ff == ST_DIV) begin
         sh = {div_r_ff[DW-1:0], div_n_ff[DW+FW-1]};
         div_n_in = {div_n_ff[DW+FW-2:0], 1'b0};
         if (sh >= {1'b0, den_ff}) begin
            div_r_in = sh - {1'b0, den_ff};
            div_f_in = {div_f_ff[FW-1:0], 1'b1};
         end else begin
            div_r_in = sh;
            div_f_in = {div_f_ff[FW-1:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in; hi_ff <= hi_in; n_ff <= n_in; q_ff <= q_in; t0_ff <= t0_in;
      a_x_ff <= a_x_in; a_y_ff <= a_y_in; a_z_ff <= a_z_in;
      b_x_ff <= b_x_in; b_y_ff <= b_y_in; b_z_ff <= b_z_in;
      den_ff <= den_in; it_ff <= it_in;
      frac_ff <= frac_in;
      p_x_ff <= p_x_in; p_y_ff <= p_y_in; p_z_ff <= p_z_in;
      wk_ff <= wk_in;
      res_ff <= res_in;
      div_r_ff <= div_r_in; div_n_ff <= div_n_in; div_f_ff <= div_f_in;
      if (reset) begin
         st_ff <= ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = res_ff;

endmodule

/* hdl/vector_keyframe_track_sampler_core.sv */
// ----------------------------------------------------------------------------
// vector_keyframe_track_sampler_core
// keyframe track store with linear sampling of three-component vectors
// ----------------------------------------------------------------------------
// requests enter through a queue port (req_push / req_full). a load request
// writes one key slot and gives no result; a query request gives one result
// on the rsp_ port (rsp_empty / rsp_pop): found flag, upper key index and the
// sampled x, y, z values.
// a two-entry request queue decouples intake from the sequencer; a request
// is registered there before the sequencer takes it. a load is written
// when it is taken. a query runs a binary search of up to p = ceil(log2(count+1))
// probes, each a registered read, then a bit-serial fraction divide (a setup
// step, then one shift per quotient bit), the blend (multiply, then sum) and
// a step to post the result.
// a query before the first key or at or after the last skips the divide.
// an empty track answers without a search. queries run one at a time.
// the result register holds one result; while it is not popped the next
// query is still worked and then waits finished in the sequencer, after
// which the request queue fills and req_full rises.
// reset clears control state and key_count; key memory content is undefined
// until loaded. key_count is written at csr address 0.
// ----------------------------------------------------------------------------
module vector_keyframe_track_sampler_core
   import vkts_pkg::*;
#(
   parameter int MAX_KEYS      = MaxKeysDefault,
   parameter int FRACTION_BITS = FractionBitsDefault
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   input  req_type       req_data,
   output logic          req_full,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output rsp_type       rsp_data,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   logic                  q_valid, q_take, rsp_valid;
   req_type               q_data;
   logic [CountWidth-1:0] key_count_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == RegKeyCount && csr_paddr[1:0] == 2'd0) begin
         key_count_ff <= csr_pwdata[CountWidth-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == RegKeyCount) ? 32'(key_count_ff) : 32'd0;

   vkts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (req_data),
      .full      (req_full),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_take    (q_take)
   );

   vkts_back #(
      .MAX_KEYS      (MAX_KEYS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_take    (q_take),
      .key_count (key_count_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_take  (rsp_pop)
   );

   assign rsp_empty = !rsp_valid;

endmodule

/* hdl/vkts_checker.sv */
// ----------------------------------------------------------------------------
// vkts_checker
// port-level checks of the track sampler
// ----------------------------------------------------------------------------
module vkts_checker
   import vkts_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data,
   input logic    csr_pready
);

   // a held result does not change
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_data))
      else $error("result changed while waiting");

   // empty track results carry zeros
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.found |-> rsp_data.upper_key == '0)
      else $error("not-found result with nonzero key");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.found |->
         rsp_data.out_x == '0 && rsp_data.out_y == '0 && rsp_data.out_z == '0)
      else $error("not-found result with nonzero value");

   assert property (@(posedge clock) $past(reset) |-> rsp_empty && !req_full)
      else $error("not idle after reset");

   assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind vector_keyframe_track_sampler_core vkts_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_full   (req_full),
   .rsp_empty  (rsp_empty),
   .rsp_pop    (rsp_pop),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);
